>>> hdl/gbts_pkg.sv
// Package for the gap buffer text store: sizes, operation codes, controller
// states and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package gbts_pkg;

    // Store size and the widths that follow from it.
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = $clog2(CAPACITY + 1);
    localparam int BYTE_W   = 8;

    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    // Operation codes carried by the mode field.
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_MOVE   = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MV_STEP,
        S_MV_WR,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ins_wr;    // write the inserted byte at the gap start
        logic del;       // pull the gap start back by the count
        logic tgt_ld;    // latch the move target
        logic rd_issue;  // read the store at the mapped logical position
        logic mv_rd;     // read the byte that crosses the gap
        logic mv_wr;     // write it on the other side and shift the gap
        logic show_byte; // present the read data on the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ins_ok;
        logic del_ok;
        logic mv_ok;
        logic rd_ok;
        logic mv_done;
    } t_dp_stat;

endpackage

>>> hdl/gbts_datapath.sv
// Datapath of the gap buffer text store: the byte store, the gap pointers,
// the move target and the result fields. Depends on gbts_pkg.
`timescale 1ns / 1ps

module gbts_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [gbts_pkg::BYTE_W-1:0]   i_ch,
    input  logic [gbts_pkg::POS_W-1:0]    i_position,
    input  logic [gbts_pkg::POS_W-1:0]    i_count,
    input  gbts_pkg::t_dp_cmd             i_cmd,
    output gbts_pkg::t_dp_stat            o_stat,
    output logic [gbts_pkg::BYTE_W-1:0]   o_read_byte,
    output logic [gbts_pkg::POS_W-1:0]    o_text_length,
    output logic [gbts_pkg::POS_W-1:0]    o_cursor
);
    import gbts_pkg::*;

    logic [BYTE_W-1:0] mem [CAPACITY];
    logic [BYTE_W-1:0] r_mem_q;

    logic [POS_W-1:0] r_gap_start, n_gap_start;
    logic [POS_W-1:0] r_gap_end,   n_gap_end;
    logic [POS_W-1:0] r_target;

    logic [POS_W-1:0]  gap_size;
    logic [POS_W-1:0]  text_len;
    logic [POS_W-1:0]  rd_index;
    logic              mv_fwd;
    logic [POS_W-1:0]  gs_m1;
    logic [POS_W-1:0]  ge_m1;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;

    // Text length and the checks that decide each operation.
    assign gap_size = r_gap_end - r_gap_start;
    assign text_len = CAP_POS - gap_size;
    assign gs_m1    = r_gap_start - POS_W'(1);
    assign ge_m1    = r_gap_end - POS_W'(1);
    assign mv_fwd   = (r_target > r_gap_start);

    assign o_stat.ins_ok  = (r_gap_start < r_gap_end);
    assign o_stat.del_ok  = (i_count <= r_gap_start);
    assign o_stat.mv_ok   = (i_position <= text_len);
    assign o_stat.rd_ok   = (i_position < text_len);
    assign o_stat.mv_done = (r_gap_start == r_target);

    // Logical position to store index: positions at or past the cursor skip the gap.
    assign rd_index = (i_position >= r_gap_start) ? (i_position + gap_size) : i_position;

    // Store port selection for reads.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = rd_index[ADDR_W-1:0];
        if (i_cmd.rd_issue) begin
            rd_en = 1'b1;
        end else if (i_cmd.mv_rd) begin
            rd_en   = 1'b1;
            rd_addr = mv_fwd ? r_gap_end[ADDR_W-1:0] : gs_m1[ADDR_W-1:0];
        end
    end

    // Store port selection for writes.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_gap_start[ADDR_W-1:0];
        wr_data = i_ch;
        if (i_cmd.ins_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.mv_wr) begin
            wr_en   = 1'b1;
            wr_addr = mv_fwd ? r_gap_start[ADDR_W-1:0] : ge_m1[ADDR_W-1:0];
            wr_data = r_mem_q;
        end
    end

    // Byte store with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // Next gap pointers.
    always_comb begin
        n_gap_start = r_gap_start;
        n_gap_end   = r_gap_end;
        if (i_cmd.ins_wr) begin
            n_gap_start = r_gap_start + POS_W'(1);
        end else if (i_cmd.del) begin
            n_gap_start = r_gap_start - i_count;
        end else if (i_cmd.mv_wr) begin
            if (mv_fwd) begin
                n_gap_start = r_gap_start + POS_W'(1);
                n_gap_end   = r_gap_end + POS_W'(1);
            end else begin
                n_gap_start = gs_m1;
                n_gap_end   = ge_m1;
            end
        end
    end

    // Gap pointers reset to an empty text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_start <= '0;
            r_gap_end   <= CAP_POS;
        end else begin
            r_gap_start <= n_gap_start;
            r_gap_end   <= n_gap_end;
        end
    end

    // Move target, held for the length of a move.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_ld) begin
            r_target <= i_position;
        end
    end

    // Result fields.
    assign o_read_byte   = i_cmd.show_byte ? r_mem_q : '0;
    assign o_text_length = text_len;
    assign o_cursor      = r_gap_start;

endmodule

>>> hdl/gbts_ctrl.sv
// Controller of the gap buffer text store: decodes each operation, sequences
// the byte-by-byte gap move and marks the result cycle. Depends on gbts_pkg.
`timescale 1ns / 1ps

module gbts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  gbts_pkg::t_mode     i_mode,
    input  gbts_pkg::t_dp_stat  i_stat,
    output gbts_pkg::t_dp_cmd   o_cmd,
    output logic                busy,
    output logic                o_done,
    output logic                o_ok
);
    import gbts_pkg::*;

    t_state r_state, n_state;
    logic   r_ok,    n_ok;
    logic   r_show,  n_show;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_mode == MODE_MOVE && i_stat.mv_ok) begin
                        n_state = S_MV_STEP;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_MV_STEP: begin
                n_state = i_stat.mv_done ? S_RESP : S_MV_WR;
            end
            S_MV_WR: begin
                n_state = S_MV_STEP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands and result flags.
    always_comb begin
        o_cmd           = '0;
        o_cmd.show_byte = r_show;
        n_ok            = r_ok;
        n_show          = r_show;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_show = 1'b0;
                    unique case (i_mode)
                        MODE_INSERT: begin
                            o_cmd.ins_wr = i_stat.ins_ok;
                            n_ok         = i_stat.ins_ok;
                        end
                        MODE_DELETE: begin
                            o_cmd.del = i_stat.del_ok;
                            n_ok      = i_stat.del_ok;
                        end
                        MODE_MOVE: begin
                            o_cmd.tgt_ld = i_stat.mv_ok;
                            n_ok         = i_stat.mv_ok;
                        end
                        MODE_READ: begin
                            o_cmd.rd_issue = i_stat.rd_ok;
                            n_ok           = i_stat.rd_ok;
                            n_show         = i_stat.rd_ok;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_MV_STEP: begin
                o_cmd.mv_rd = !i_stat.mv_done;
            end
            S_MV_WR: begin
                o_cmd.mv_wr = 1'b1;
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // State and flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ok    <= 1'b0;
            r_show  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
            r_show  <= n_show;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);
    assign o_ok   = r_ok;

endmodule

>>> hdl/gap_buffer_text_store_unit.sv
// Top level of the gap buffer text store: controller and datapath.
// Depends on gbts_pkg, gbts_ctrl and gbts_datapath.
//
// Channel   Direction  Handshake             Payload
// command   in         start high, busy low  i_mode, i_ch, i_position, i_count
// result    out        o_done, one cycle     o_ok, o_read_byte, o_text_length, o_cursor
//
// Insert, delete, read and every rejected operation go from idle straight to the result
// state, with the result strobe in the cycle after the accepting edge. A move steps the
// gap byte by byte: each byte that crosses the gap is read in the step state and written
// from the registered read data in the write state that follows.
// A synchronous active-low reset empties the text and idles the controller.
// The result is shown for one cycle and cannot be held off; busy stays high until it is.
`timescale 1ns / 1ps

module gap_buffer_text_store_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_mode,
    input  logic [gbts_pkg::BYTE_W-1:0]   i_ch,
    input  logic [gbts_pkg::POS_W-1:0]    i_position,
    input  logic [gbts_pkg::POS_W-1:0]    i_count,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [gbts_pkg::BYTE_W-1:0]   o_read_byte,
    output logic [gbts_pkg::POS_W-1:0]    o_text_length,
    output logic [gbts_pkg::POS_W-1:0]    o_cursor
);
    import gbts_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Operation sequencing.
    gbts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (t_mode'(i_mode)),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_ok    (o_ok)
    );

    // Store, gap pointers and result fields.
    gbts_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch          (i_ch),
        .i_position    (i_position),
        .i_count       (i_count),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_read_byte   (o_read_byte),
        .o_text_length (o_text_length),
        .o_cursor      (o_cursor)
    );

    // An accepted transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted transaction");

    // A result strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // The cursor never lies beyond the end of the text.
    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_cursor <= o_text_length))
        else $error("cursor beyond text length");

    // A rejected operation reports a zero byte.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_read_byte == '0))
        else $error("rejected transaction reports a nonzero byte");

endmodule
